[src/cycloid_foot_trajectory_unit_assert.svh]
// Assertion macros for the cycloid foot trajectory unit.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef CYCLOID_FOOT_TRAJECTORY_UNIT_ASSERT_SVH
`define CYCLOID_FOOT_TRAJECTORY_UNIT_ASSERT_SVH

// same-cycle implication
`define CFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cft_pkg.sv]
// ----------------------------------------------------------------------------
// cft_pkg
// Shared widths, constants and types of the cycloid foot trajectory unit.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam int PHASE_W = 24;
  localparam int LEN_W   = 18;
  localparam int DUTY_W  = 17;
  localparam int HGT_W   = 16;
  localparam int OX_W    = 18;
  localparam int OZ_W    = 16;
  localparam int T_W     = 16;

  localparam logic [DUTY_W-1:0] DUTY_RST = 17'd39322;
  localparam logic [DUTY_W-1:0] DUTY_ONE = 17'd65536;
  localparam logic [HGT_W-1:0]  HGT_RST  = 16'd3277;

  // 2*pi as Q3.30 and 1/(2*pi) as Q0.30; ONE_Q30 is Q2.30
  localparam logic [32:0] TWO_PI_Q30     = 33'd6746518852;
  localparam logic [27:0] INV_TWO_PI_Q30 = 28'd170891319;
  localparam logic [31:0] ONE_Q30        = 32'h4000_0000;

  localparam int ROUNDS     = 8;
  localparam int DIV_STAGES = 6;
  localparam int DIV_BITS   = 3;
  localparam int QUO_W      = DIV_STAGES * DIV_BITS;
  localparam int NUM_W      = 36;
  localparam int DEN_W      = 18;

  typedef enum logic {
    REG_DUTY   = 1'b0,
    REG_HEIGHT = 1'b1
  } cft_reg_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } cft_quad_e;

  // per-word data that rides along the pipeline
  typedef struct packed {
    logic                    stance;
    logic signed [LEN_W-1:0] len;
    logic signed [OX_W-1:0]  dx_st;
    logic [T_W-1:0]          t;
  } cft_side_t;

endpackage

[src/cft_taylor_round.sv]
// ----------------------------------------------------------------------------
// cft_taylor_round
// One Taylor round for cosine and, while K <= 7, sine: term*a*a/const, four stages deep.
// ----------------------------------------------------------------------------
module cft_taylor_round #(
  parameter int K = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  cft_pkg::cft_side_t  side_i,
  input  logic [31:0]         a_i,
  input  logic [31:0]         st_i,
  input  logic [31:0]         ct_i,
  input  logic signed [33:0]  sa_i,
  input  logic signed [33:0]  ca_i,
  output logic                valid_o,
  output cft_pkg::cft_side_t  side_o,
  output logic [31:0]         a_o,
  output logic [31:0]         st_o,
  output logic [31:0]         ct_o,
  output logic signed [33:0]  sa_o,
  output logic signed [33:0]  ca_o
);

  localparam int DS = (2 * K) * (2 * K + 1);
  localparam int DC = (2 * K - 1) * (2 * K);
  localparam logic [63:0] MS = (64'd1 << 32) / 64'(DS);
  localparam logic [63:0] MC = (64'd1 << 32) / 64'(DC);
  localparam bit DO_SIN = (K <= 7);
  localparam bit SUB    = ((K % 2) == 1);

  logic [3:0] v_q;
  cft_pkg::cft_side_t side1_q, side2_q, side3_q, side4_q;
  logic [31:0] a1_q, a2_q, a3_q, a4_q;
  logic signed [33:0] sa1_q, sa2_q, sa3_q, sa4_q, ca1_q, ca2_q, ca3_q, ca4_q;
  logic [31:0] sp1_q, cp1_q, sp2_q, cp2_q, sn3_q, cn3_q, sf4_q, cf4_q;
  logic [63:0] sx3_q, cx3_q;

  logic [63:0] sm1, cm1, sm2, cm2;
  logic [31:0] sq, cq, sqd, cqd, srem, crem, sfin, cfin;
  logic signed [33:0] sa_d, ca_d;

  assign sm1 = 64'(st_i) * 64'(a_i);
  assign cm1 = 64'(ct_i) * 64'(a_i);
  assign sm2 = 64'(sp1_q) * 64'(a1_q);
  assign cm2 = 64'(cp1_q) * 64'(a1_q);

  // reciprocal estimate is low by at most one
  always_comb begin
    sq   = sx3_q[63:32];
    cq   = cx3_q[63:32];
    sqd  = 32'(sq * 32'(DS));
    cqd  = 32'(cq * 32'(DC));
    srem = sn3_q - sqd;
    crem = cn3_q - cqd;
    sfin = (srem >= 32'(DS)) ? sq + 32'd1 : sq;
    cfin = (crem >= 32'(DC)) ? cq + 32'd1 : cq;
    if (!DO_SIN) begin
      sa_d = sa3_q;
    end else if (SUB) begin
      sa_d = sa3_q - $signed({2'b00, sfin});
    end else begin
      sa_d = sa3_q + $signed({2'b00, sfin});
    end
    if (SUB) begin
      ca_d = ca3_q - $signed({2'b00, cfin});
    end else begin
      ca_d = ca3_q + $signed({2'b00, cfin});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;  a1_q <= a_i;  sa1_q <= sa_i;  ca1_q <= ca_i;
      sp1_q   <= sm1[61:30];
      cp1_q   <= cm1[61:30];
      side2_q <= side1_q; a2_q <= a1_q; sa2_q <= sa1_q; ca2_q <= ca1_q;
      sp2_q   <= sm2[61:30];
      cp2_q   <= cm2[61:30];
      side3_q <= side2_q; a3_q <= a2_q; sa3_q <= sa2_q; ca3_q <= ca2_q;
      sn3_q   <= sp2_q;
      cn3_q   <= cp2_q;
      sx3_q   <= 64'(sp2_q) * 64'(MS[31:0]);
      cx3_q   <= 64'(cp2_q) * 64'(MC[31:0]);
      side4_q <= side3_q; a4_q <= a3_q;
      sa4_q   <= sa_d;
      ca4_q   <= ca_d;
      sf4_q   <= sfin;
      cf4_q   <= cfin;
    end
  end

  assign valid_o = v_q[3];
  assign side_o  = side4_q;
  assign a_o     = a4_q;
  assign st_o    = sf4_q;
  assign ct_o    = cf4_q;
  assign sa_o    = sa4_q;
  assign ca_o    = ca4_q;

endmodule

[src/cycloid_foot_trajectory_unit.sv]
// ----------------------------------------------------------------------------
// cycloid_foot_trajectory_unit
// Foot offset and stance flag of one leg from its phase and step length.
// ----------------------------------------------------------------------------
// Input channel: phase_i (signed Q8.16, fraction used) and step_length_i,
// taken when in_valid_i and in_ready_o are both high. Output channel:
// offset_x_o, offset_z_o and stance_o under out_valid_o / out_ready_i.
// The APB port holds duty_fraction at 0x0 and step_height at 0x4; write
// them only while no word is in flight.
// Throughput is one word per cycle unless a finished word waits with
// out_ready_i low: every stage is a register slice that takes a new word
// each cycle. The path is 3 front stages, a 6-stage radix-8 divider shared
// by the stance and swing paths, 1 angle stage, 8 Taylor rounds of 4 stages
// for sine/cosine, and 4 back-end stages ending in the output register.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls, the whole pipeline holds in place; in_ready_o
// is low exactly while a finished word waits and out_ready_i is low.
// ----------------------------------------------------------------------------
module cycloid_foot_trajectory_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [cft_pkg::PHASE_W-1:0]   phase_i,
  input  logic signed [cft_pkg::LEN_W-1:0]     step_length_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [cft_pkg::OX_W-1:0]      offset_x_o,
  output logic [cft_pkg::OZ_W-1:0]             offset_z_o,
  output logic                                 stance_o
);

  localparam int DS = cft_pkg::DIV_STAGES;
  localparam int NR = cft_pkg::ROUNDS;

  // ---------------- configuration ----------------
  logic [cft_pkg::DUTY_W-1:0] duty_q, duty_c;
  logic [cft_pkg::HGT_W-1:0]  hgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= cft_pkg::DUTY_RST;
      hgt_q  <= cft_pkg::HGT_RST;
    end else if (psel && penable && pwrite) begin
      case (cft_pkg::cft_reg_e'(paddr[2]))
        cft_pkg::REG_DUTY:   duty_q <= pwdata[cft_pkg::DUTY_W-1:0];
        cft_pkg::REG_HEIGHT: hgt_q  <= pwdata[cft_pkg::HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cft_pkg::cft_reg_e'(paddr[2]))
      cft_pkg::REG_DUTY:   prdata = 32'(duty_q);
      cft_pkg::REG_HEIGHT: prdata = 32'(hgt_q);
      default:             prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign duty_c = (duty_q > cft_pkg::DUTY_ONE) ? cft_pkg::DUTY_ONE : duty_q;

  // ---------------- flow control ----------------
  logic out_valid_q, en;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------- S0: input register ----------------
  logic v0_q;
  logic [15:0] p0_q;
  logic signed [cft_pkg::LEN_W-1:0] len0_q;

  // ---------------- S1: stance test, stance product ----------------
  logic v1_q, stance1_q;
  logic [15:0] p1_q;
  logic signed [cft_pkg::LEN_W-1:0] len1_q;
  logic signed [36:0] prod1_q;
  logic signed [18:0] dm;
  logic stance1_d;

  assign stance1_d = ({1'b0, p0_q} < duty_c);
  assign dm = $signed({2'b00, duty_c}) - $signed({2'b00, p0_q, 1'b0});

  // ---------------- S2 and divider ----------------
  logic [cft_pkg::NUM_W-1:0] num2_d;
  logic [cft_pkg::DEN_W-1:0] den2_d;
  logic [36:0] mag1;

  logic                      dv_q   [DS+1];
  logic                      dneg_q [DS+1];
  cft_pkg::cft_side_t        dside_q[DS+1];
  logic [cft_pkg::DEN_W-1:0] dden_q [DS+1];
  logic [17:0]               drem_q [DS+1];
  logic [17:0]               dlow_q [DS+1];
  logic [cft_pkg::QUO_W-1:0] dquo_q [DS+1];

  always_comb begin
    mag1 = prod1_q[36] ? 37'(-prod1_q) : 37'(prod1_q);
    if (stance1_q) begin
      num2_d = cft_pkg::NUM_W'(mag1) + cft_pkg::NUM_W'(duty_c);
      den2_d = {duty_c, 1'b0};
    end else begin
      num2_d = {4'b0000, p1_q - duty_c[15:0], 16'h0000};
      den2_d = cft_pkg::DEN_W'(cft_pkg::DUTY_ONE - duty_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      dv_q[0]   <= 1'b0;
    end else if (en) begin
      v0_q      <= in_valid_i;
      v1_q      <= v0_q;
      dv_q[0]   <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q       <= phase_i[15:0];
      len0_q     <= step_length_i;
      stance1_q  <= stance1_d;
      p1_q       <= p0_q;
      len1_q     <= len0_q;
      prod1_q    <= 37'(len0_q) * 37'(dm);
      dneg_q[0]  <= prod1_q[36];
      dside_q[0] <= '{stance: stance1_q, len: len1_q, dx_st: '0, t: '0};
      dden_q[0]  <= den2_d;
      drem_q[0]  <= num2_d[35:18];
      dlow_q[0]  <= num2_d[17:0];
      dquo_q[0]  <= '0;
    end
  end

  // restoring division, three quotient bits per stage
  for (genvar j = 1; j <= DS; j++) begin : g_div
    logic [17:0]               r_d, lo_d;
    logic [cft_pkg::QUO_W-1:0] q_d;

    always_comb begin
      logic [18:0] r19;
      r_d  = drem_q[j-1];
      lo_d = dlow_q[j-1];
      q_d  = dquo_q[j-1];
      for (int b = 0; b < cft_pkg::DIV_BITS; b++) begin
        r19  = {r_d, lo_d[17]};
        lo_d = {lo_d[16:0], 1'b0};
        if (r19 >= {1'b0, dden_q[j-1]}) begin
          r19 = r19 - {1'b0, dden_q[j-1]};
          q_d = {q_d[cft_pkg::QUO_W-2:0], 1'b1};
        end else begin
          q_d = {q_d[cft_pkg::QUO_W-2:0], 1'b0};
        end
        r_d = r19[17:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en) begin
        dv_q[j] <= dv_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dneg_q[j]  <= dneg_q[j-1];
        dside_q[j] <= dside_q[j-1];
        dden_q[j]  <= dden_q[j-1];
        drem_q[j]  <= r_d;
        dlow_q[j]  <= lo_d;
        dquo_q[j]  <= q_d;
      end
    end
  end

  // ---------------- stage A: stance result, angle ----------------
  logic [cft_pkg::QUO_W-1:0] qa;
  logic signed [18:0] sq19;
  logic signed [cft_pkg::OX_W-1:0] dxst_d;
  logic [46:0] ang;
  cft_pkg::cft_side_t sideA_d, sideA_q;
  logic vA_q;
  logic [31:0] aA_q;

  always_comb begin
    qa   = dquo_q[DS];
    sq19 = dneg_q[DS] ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
    if (sq19 > 19'sd131071) begin
      dxst_d = 18'sd131071;
    end else if (sq19 < -19'sd131072) begin
      dxst_d = -18'sd131072;
    end else begin
      dxst_d = sq19[17:0];
    end
    sideA_d       = dside_q[DS];
    sideA_d.dx_st = dxst_d;
    sideA_d.t     = qa[15:0];
    ang           = 47'(qa[13:0]) * 47'(cft_pkg::TWO_PI_Q30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vA_q <= 1'b0;
    end else if (en) begin
      vA_q <= dv_q[DS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sideA_q <= sideA_d;
      aA_q    <= {1'b0, ang[46:16]};
    end
  end

  // ---------------- Taylor rounds ----------------
  logic               rv   [NR+1];
  cft_pkg::cft_side_t rside[NR+1];
  logic [31:0]        ra   [NR+1];
  logic [31:0]        rst  [NR+1];
  logic [31:0]        rct  [NR+1];
  logic signed [33:0] rsa  [NR+1];
  logic signed [33:0] rca  [NR+1];

  assign rv[0]    = vA_q;
  assign rside[0] = sideA_q;
  assign ra[0]    = aA_q;
  assign rst[0]   = aA_q;
  assign rct[0]   = cft_pkg::ONE_Q30;
  assign rsa[0]   = $signed({2'b00, aA_q});
  assign rca[0]   = $signed({2'b00, cft_pkg::ONE_Q30});

  for (genvar k = 1; k <= NR; k++) begin : g_round
    cft_taylor_round #(
      .K(k)
    ) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(rv[k-1]),
      .side_i (rside[k-1]),
      .a_i    (ra[k-1]),
      .st_i   (rst[k-1]),
      .ct_i   (rct[k-1]),
      .sa_i   (rsa[k-1]),
      .ca_i   (rca[k-1]),
      .valid_o(rv[k]),
      .side_o (rside[k]),
      .a_o    (ra[k]),
      .st_o   (rst[k]),
      .ct_o   (rct[k]),
      .sa_o   (rsa[k]),
      .ca_o   (rca[k])
    );
  end

  // ---------------- P1: quadrant fold ----------------
  logic signed [33:0] ss_d, cc_d, ss_q, cc_q;
  cft_pkg::cft_side_t sideP1_q, sideP2_q, sideP3_q;
  logic vP1_q, vP2_q, vP3_q;

  always_comb begin
    case (cft_pkg::cft_quad_e'(rside[NR].t[15:14]))
      cft_pkg::QUAD_0: begin ss_d = rsa[NR];  cc_d = rca[NR];  end
      cft_pkg::QUAD_1: begin ss_d = rca[NR];  cc_d = -rsa[NR]; end
      cft_pkg::QUAD_2: begin ss_d = -rsa[NR]; cc_d = -rca[NR]; end
      default:         begin ss_d = -rca[NR]; cc_d = rsa[NR];  end
    endcase
  end

  // ---------------- P2: cycloid term and lift ----------------
  logic [33:0] smag;
  logic [59:0] sdp;
  logic signed [33:0] sd, f_d, f_q;
  logic signed [34:0] lift35;
  logic [32:0] lift_d, lift_q;

  always_comb begin
    smag   = ss_q[33] ? 34'(-ss_q) : 34'(ss_q);
    sdp    = 60'(smag[31:0]) * 60'(cft_pkg::INV_TWO_PI_Q30);
    sd     = ss_q[33] ? -$signed({4'b0000, sdp[59:30]}) : $signed({4'b0000, sdp[59:30]});
    f_d    = $signed({4'b0000, sideP1_q.t, 14'h0000}) - sd - 34'sd536870912;
    lift35 = 35'sd1073741824 - 35'(cc_q);
    lift_d = lift35[34] ? 33'd0 : lift35[32:0];
  end

  // ---------------- P3: scale ----------------
  logic signed [51:0] px_q;
  logic [48:0] pz_q;

  // ---------------- P4: round, saturate, output register ----------------
  logic [51:0] mx, rsum;
  logic signed [22:0] dxw;
  logic signed [cft_pkg::OX_W-1:0] dxs;
  logic [49:0] zsum;
  logic [cft_pkg::OZ_W-1:0] dzs;
  logic signed [cft_pkg::OX_W-1:0] ox_q;
  logic [cft_pkg::OZ_W-1:0] oz_q;
  logic st_q;

  always_comb begin
    mx   = px_q[51] ? 52'(-px_q) : 52'(px_q);
    rsum = mx + 52'd536870912;
    dxw  = px_q[51] ? -$signed({1'b0, rsum[51:30]}) : $signed({1'b0, rsum[51:30]});
    if (dxw > 23'sd131071) begin
      dxs = 18'sd131071;
    end else if (dxw < -23'sd131072) begin
      dxs = -18'sd131072;
    end else begin
      dxs = dxw[17:0];
    end
    zsum = 50'(pz_q) + 50'd1073741824;
    dzs  = (zsum[49:31] > 19'd65535) ? 16'hFFFF : zsum[46:31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vP1_q       <= 1'b0;
      vP2_q       <= 1'b0;
      vP3_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vP1_q       <= rv[NR];
      vP2_q       <= vP1_q;
      vP3_q       <= vP2_q;
      out_valid_q <= vP3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sideP1_q <= rside[NR];
      ss_q     <= ss_d;
      cc_q     <= cc_d;
      sideP2_q <= sideP1_q;
      f_q      <= f_d;
      lift_q   <= lift_d;
      sideP3_q <= sideP2_q;
      px_q     <= 52'($signed(sideP2_q.len)) * 52'(f_q);
      pz_q     <= 49'(lift_q) * 49'(hgt_q);
      ox_q     <= sideP3_q.stance ? sideP3_q.dx_st : dxs;
      oz_q     <= sideP3_q.stance ? '0 : dzs;
      st_q     <= sideP3_q.stance;
    end
  end

  assign out_valid_o = out_valid_q;
  assign offset_x_o  = ox_q;
  assign offset_z_o  = oz_q;
  assign stance_o    = st_q;

endmodule

[src/cft_checker.sv]
// ----------------------------------------------------------------------------
// cft_checker
// Port-level checks of the cycloid foot trajectory unit, bound to the top.
// ----------------------------------------------------------------------------
`include "cycloid_foot_trajectory_unit_assert.svh"

module cft_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic signed [cft_pkg::OX_W-1:0] offset_x_o,
  input logic [cft_pkg::OZ_W-1:0]        offset_z_o,
  input logic                            stance_o
);

  `CFT_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(offset_x_o) && $stable(offset_z_o) && $stable(stance_o), "stalled result word changed")
  `CFT_ASSERT_IMP(a_in_ready, 1'b1, in_ready_o == (!out_valid_o || out_ready_i), "input ready does not follow the output stage")
  `CFT_ASSERT_IMP(a_stance_flat, out_valid_o && stance_o, offset_z_o == '0, "foot lifted during stance")

endmodule

bind cycloid_foot_trajectory_unit cft_checker u_cft_checker (.*);
